FILE: rtl/esag_pkg.sv
`default_nettype none

package esag_pkg;

  // field and register widths
  localparam int BS_W    = 21;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int START_W = 48;
  localparam int LEN_W   = 32;
  localparam int BYTES_W = 52;
  localparam int OFF_W   = 64;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // split point of the start block for the two partial products
  localparam int START_LO_W = 24;
  localparam int START_HI_W = START_W - START_LO_W;
  localparam int PROD_W     = START_LO_W + BS_W;

  // parameter defaults
  localparam int MAX_EXTENTS_DEF = 16;

  // register reset values and limits
  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 21'd4096;
  localparam logic [BS_W-1:0]  BLOCK_SIZE_MAX = 21'd1048576;
  localparam logic [CNT_W-1:0] EXTENT_COUNT_RST = 5'd0;

  // register index, taken from paddr[2]
  localparam logic REG_BLOCK_SIZE   = 1'b0;
  localparam logic REG_EXTENT_COUNT = 1'b1;

  // item kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_WRITE = 2'd0,
    ST_HOLE  = 2'd1,
    ST_OOB   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic begin_chunk;
    logic rd;
    logic mul_len;
    logic mul_lo;
    logic mul_hi;
    logic emit_err;
    logic emit_piece;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic chunk_zero;
    logic oob;
    logic ext_empty;
    logic piece_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/esag_ram.sv
`default_nettype none

module esag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/esag_regs.sv
`default_nettype none

module esag_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [esag_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [esag_pkg::PDATA_W-1:0]  pwdata,
  output logic      [esag_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output logic      [esag_pkg::BS_W-1:0]     bs_eff,
  output logic      [esag_pkg::CNT_W-1:0]    extent_count
);

  import esag_pkg::*;

  logic [BS_W-1:0] block_size;
  logic            wr_en;
  logic [BS_W-1:0] wr_bs;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_bs  = pwdata[BS_W-1:0];

  // register writes; clamped block size kept alongside the raw value
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= BLOCK_SIZE_RST;
      bs_eff       <= BLOCK_SIZE_RST;
      extent_count <= EXTENT_COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE: begin
          block_size <= wr_bs;
          bs_eff     <= (wr_bs > BLOCK_SIZE_MAX) ? BLOCK_SIZE_MAX : wr_bs;
        end
        REG_EXTENT_COUNT: begin
          extent_count <= pwdata[CNT_W-1:0];
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SIZE:   prdata = PDATA_W'(block_size);
      REG_EXTENT_COUNT: prdata = PDATA_W'(extent_count);
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/esag_ctrl.sv
`default_nettype none

module esag_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               req_type,
  input  wire esag_pkg::dp_stat_t stat,
  output esag_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    valid
);

  import esag_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_LOAD) begin
            cmd.load = 1'b1;
          end else if (!stat.chunk_zero) begin
            cmd.begin_chunk = 1'b1;
            state_next      = S_READ;
          end
        end
      end
      S_READ: begin
        if (stat.oob) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_len = 1'b1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_hi = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_piece = 1'b1;
        state_next     = (stat.ext_empty || stat.piece_last) ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      valid <= cmd.emit_err || cmd.emit_piece;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/esag_dp.sv
`default_nettype none

module esag_dp #(
  parameter int MAX_EXTENTS = esag_pkg::MAX_EXTENTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire esag_pkg::dp_cmd_t             cmd,
  output esag_pkg::dp_stat_t                 stat,
  input  wire logic [esag_pkg::BS_W-1:0]     bs_eff,
  input  wire logic [esag_pkg::CNT_W-1:0]    extent_count,
  input  wire logic [esag_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [esag_pkg::START_W-1:0]  first_block,
  input  wire logic [esag_pkg::LEN_W-1:0]    block_count,
  input  wire logic                          is_hole,
  input  wire logic [esag_pkg::LEN_W-1:0]    chunk_length,
  output logic      [1:0]                    status,
  output logic      [esag_pkg::OFF_W-1:0]    write_offset,
  output logic      [esag_pkg::LEN_W-1:0]    piece_length,
  output logic                               last
);

  import esag_pkg::*;

  localparam int AW     = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW     = $clog2(MAX_EXTENTS + 1);
  localparam int ENT_W  = 1 + LEN_W + START_W;
  localparam int EXT_W  = LEN_W + BS_W;

  // walk position
  logic [CW-1:0]      cur_ext;
  logic [BYTES_W-1:0] bytes_into;
  logic [LEN_W-1:0]   left;

  // per-extent working registers
  logic [START_W-1:0] ext_start;
  logic               ext_hole;
  logic [BYTES_W-1:0] ext_bytes;
  logic [PROD_W-1:0]  prod_lo;
  logic [PROD_W-1:0]  prod_hi;
  logic [BYTES_W-1:0] remain;
  logic               empty;
  logic [OFF_W-1:0]   base;
  logic [LEN_W-1:0]   piece;
  logic               piece_lt;
  logic               piece_last;

  // table memory
  logic               slot_ok;
  logic [ENT_W-1:0]   ram_wdata;
  logic [ENT_W-1:0]   ram_rdata;
  logic [START_W-1:0] rd_start;
  logic [LEN_W-1:0]   rd_len;
  logic               rd_hole;

  // combinational helpers
  logic [EXT_W-1:0]   len_prod;
  logic [PROD_W-1:0]  lo_prod;
  logic [PROD_W-1:0]  hi_prod;
  logic [BYTES_W:0]   diff;
  logic [OFF_W-1:0]   off_sum;
  logic               oob;

  assign slot_ok   = (32'(entry_index) < 32'(MAX_EXTENTS));
  assign ram_wdata = {is_hole, block_count, first_block};
  assign {rd_hole, rd_len, rd_start} = ram_rdata;

  esag_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_EXTENTS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load && slot_ok),
    .waddr (AW'(entry_index)),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (cur_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // out of extents: past the clamped extent count
  assign oob = (32'(cur_ext) >= 32'(extent_count)) || (32'(cur_ext) >= 32'(MAX_EXTENTS));

  assign len_prod = EXT_W'(rd_len) * EXT_W'(bs_eff);
  assign lo_prod  = PROD_W'(ext_start[START_LO_W-1:0]) * PROD_W'(bs_eff);
  assign hi_prod  = PROD_W'(ext_start[START_W-1:START_LO_W]) * PROD_W'(bs_eff);
  assign diff     = {1'b0, ext_bytes} - {1'b0, bytes_into};
  assign off_sum  = base + (OFF_W'(prod_hi) << START_LO_W);

  assign stat.chunk_zero = (chunk_length == '0);
  assign stat.oob        = oob;
  assign stat.ext_empty  = empty;
  assign stat.piece_last = piece_last;

  // walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ext    <= '0;
      bytes_into <= '0;
    end else if (cmd.emit_piece && !empty) begin
      if (!piece_lt) begin
        bytes_into <= '0;
        cur_ext    <= cur_ext + CW'(1);
      end else begin
        bytes_into <= bytes_into + BYTES_W'(piece);
      end
    end
  end

  always_ff @(posedge clk) begin
    // chunk bytes still to place
    if (cmd.begin_chunk) begin
      left <= chunk_length;
    end else if (cmd.emit_piece && !empty) begin
      left <= left - piece;
    end
    // extent size in bytes, latch the entry
    if (cmd.mul_len) begin
      ext_bytes <= BYTES_W'(len_prod);
      ext_start <= rd_start;
      ext_hole  <= rd_hole;
    end
    // low partial product, bytes left in the extent
    if (cmd.mul_lo) begin
      prod_lo <= lo_prod;
      remain  <= diff[BYTES_W-1:0];
      empty   <= diff[BYTES_W] || (diff == '0);
    end
    // high partial product, piece size, base offset
    if (cmd.mul_hi) begin
      prod_hi    <= hi_prod;
      base       <= OFF_W'(prod_lo) + OFF_W'(bytes_into);
      piece_lt   <= (BYTES_W'(left) < remain);
      piece_last <= (BYTES_W'(left) <= remain);
      piece      <= (BYTES_W'(left) < remain) ? left : remain[LEN_W-1:0];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      status       <= ST_OOB;
      write_offset <= '0;
      piece_length <= '0;
      last         <= 1'b1;
    end else if (cmd.emit_piece) begin
      if (empty) begin
        status       <= ST_EMPTY;
        write_offset <= '0;
        piece_length <= '0;
        last         <= 1'b1;
      end else begin
        status       <= ext_hole ? ST_HOLE : ST_WRITE;
        write_offset <= ext_hole ? '0 : off_sum;
        piece_length <= piece;
        last         <= piece_last;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/extent_scatter_address_gen_core.sv
`default_nettype none

// Extent scatter address generator. Load items (req_type 0) fill one slot of
// the extent table. Write items (req_type 1) walk the chunk across the table
// from the current extent and emit one result per extent touched, marked by
// valid for a single cycle; the receiver cannot hold results off, so it must
// take every strobe. Each piece takes one table memory read followed by three
// multiply stages (extent length, then the low and high halves of start block
// times block size) and the result step. Running out of extents gives one
// out-of-range result; a zero-length chunk gives no result. Results of a
// chunk appear in order, the final one with last set. The user must write
// configuration only while busy is low and no result is pending; the block
// itself does not enforce this. pready is always high.
module extent_scatter_address_gen_core #(
  parameter int MAX_EXTENTS = esag_pkg::MAX_EXTENTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type,
  input  wire logic [esag_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [esag_pkg::START_W-1:0]  first_block,
  input  wire logic [esag_pkg::LEN_W-1:0]    block_count,
  input  wire logic                          is_hole,
  input  wire logic [esag_pkg::LEN_W-1:0]    chunk_length,
  // result channel
  output logic                               valid,
  output logic      [1:0]                    status,
  output logic      [esag_pkg::OFF_W-1:0]    write_offset,
  output logic      [esag_pkg::LEN_W-1:0]    piece_length,
  output logic                               last,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [esag_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [esag_pkg::PDATA_W-1:0]  pwdata,
  output logic      [esag_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  import esag_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [BS_W-1:0]  bs_eff;
  logic [CNT_W-1:0] extent_count;

  // configuration registers
  esag_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .bs_eff       (bs_eff),
    .extent_count (extent_count)
  );

  // sequencer
  esag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start && !busy),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .valid    (valid)
  );

  // table, walk position and offset arithmetic
  esag_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .bs_eff       (bs_eff),
    .extent_count (extent_count),
    .entry_index  (entry_index),
    .first_block  (first_block),
    .block_count  (block_count),
    .is_hole      (is_hole),
    .chunk_length (chunk_length),
    .status       (status),
    .write_offset (write_offset),
    .piece_length (piece_length),
    .last         (last)
  );

endmodule

`default_nettype wire
